// File: sv/saturation_degree_graph_coloring_assert.svh
// Assertion macros shared by the colouring engine RTL.
`ifndef SATURATION_DEGREE_GRAPH_COLORING_ASSERT_SVH
`define SATURATION_DEGREE_GRAPH_COLORING_ASSERT_SVH
`ifndef SYNTH
// Property that must hold at every clock edge outside reset.
`define SDGC_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);
// Condition that must be followed by a consequence in the next cycle.
`define SDGC_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);
`else
`define SDGC_ASSERT(lbl, prop, msg)
`define SDGC_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

// File: sv/sdgc_pkg.sv
// Shared types, codes and constants of the DSATUR colouring engine.
`timescale 1ns / 1ps
package sdgc_pkg;

	localparam int DEF_MAX_NODES  = 64;
	localparam int DEF_MAX_COLORS = 16;
	localparam int LFSR_W         = 16;
	localparam logic [LFSR_W-1:0] LFSR_TAPS = 16'hB400;

	localparam logic [6:0]  RST_NODE_COUNT  = 7'd64;
	localparam logic [4:0]  RST_COLOR_COUNT = 5'd16;
	localparam logic [15:0] RST_SEED        = 16'd1;

	typedef enum logic [1:0] {
		OP_ADD   = 2'd0,
		OP_CLEAR = 2'd1,
		OP_RUN   = 2'd2,
		OP_READ  = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		REG_NODE_COUNT  = 2'd0,
		REG_COLOR_COUNT = 2'd1,
		REG_SEED        = 2'd2
	} reg_idx_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_ADD_A,
		ST_ADD_B,
		ST_READ,
		ST_SCAN,
		ST_CHOOSE,
		ST_MOD,
		ST_COMMIT,
		ST_UPD,
		ST_DONE
	} state_t;

	// Control word of a store: read, write and invalidate-all.
	typedef struct packed {
		logic rd;
		logic wr;
		logic clr;
	} mem_ctl_t;

	// One step of the Galois fallback generator.
	function automatic logic [LFSR_W-1:0] lfsr_step(input logic [LFSR_W-1:0] v);
		logic [LFSR_W-1:0] s;
		s = v >> 1;
		if (v[0]) begin
			s = s ^ LFSR_TAPS;
		end
		return s;
	endfunction

endpackage

// File: sv/sdgc_graph_mem.sv
// Adjacency row and degree store, with per-row valid bits for reset and clear.
`timescale 1ns / 1ps
module sdgc_graph_mem #(
	parameter int MAX_NODES = sdgc_pkg::DEF_MAX_NODES
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  sdgc_pkg::mem_ctl_t                 ctl,
	input  logic [$clog2(MAX_NODES)-1:0]       rd_addr,
	input  logic [$clog2(MAX_NODES)-1:0]       wr_addr,
	input  logic [MAX_NODES-1:0]               wr_row,
	input  logic [$clog2(MAX_NODES+1)-1:0]     wr_deg,
	output logic [MAX_NODES-1:0]               rd_row,
	output logic [$clog2(MAX_NODES+1)-1:0]     rd_deg
);
	import sdgc_pkg::*;

	localparam int DW = $clog2(MAX_NODES + 1);

	logic [MAX_NODES-1:0] row_mem [MAX_NODES];
	logic [DW-1:0]        deg_mem [MAX_NODES];
	logic [MAX_NODES-1:0] vld_q;
	logic [MAX_NODES-1:0] row_s1;
	logic [DW-1:0]        deg_s1;
	logic                 rvld_s1;

	// Storage array, one write and one registered read per cycle.
	always_ff @(posedge clk) begin
		if (ctl.wr) begin
			row_mem[wr_addr] <= wr_row;
			deg_mem[wr_addr] <= wr_deg;
		end
		if (ctl.rd) begin
			row_s1 <= row_mem[rd_addr];
			deg_s1 <= deg_mem[rd_addr];
		end
	end

	// Valid bits: a row that was never written since the last clear reads as zero.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q   <= '0;
			rvld_s1 <= 1'b0;
		end else begin
			if (ctl.clr) begin
				vld_q <= '0;
			end else if (ctl.wr) begin
				vld_q[wr_addr] <= 1'b1;
			end
			if (ctl.rd) begin
				rvld_s1 <= vld_q[rd_addr];
			end
		end
	end

	assign rd_row = rvld_s1 ? row_s1 : '0;
	assign rd_deg = rvld_s1 ? deg_s1 : '0;

endmodule

// File: sv/sdgc_node_mem.sv
// Per-node colouring state store, invalidated at the start of a run.
`timescale 1ns / 1ps
module sdgc_node_mem #(
	parameter int MAX_NODES  = sdgc_pkg::DEF_MAX_NODES,
	parameter int MAX_COLORS = sdgc_pkg::DEF_MAX_COLORS
) (
	input  logic                                            clk,
	input  logic                                            arst_n,
	input  sdgc_pkg::mem_ctl_t                              ctl,
	input  logic [$clog2(MAX_NODES)-1:0]                    rd_addr,
	input  logic [$clog2(MAX_NODES)-1:0]                    wr_addr,
	input  logic [$clog2(MAX_COLORS+1)-1:0]                 wr_sat,
	input  logic [MAX_COLORS-1:0]                           wr_mask,
	input  logic [((MAX_COLORS > 1) ? $clog2(MAX_COLORS) : 1)-1:0] wr_color,
	input  logic                                            wr_colored,
	input  logic                                            wr_fb,
	output logic [$clog2(MAX_COLORS+1)-1:0]                 rd_sat,
	output logic [MAX_COLORS-1:0]                           rd_mask,
	output logic [((MAX_COLORS > 1) ? $clog2(MAX_COLORS) : 1)-1:0] rd_color,
	output logic                                            rd_colored,
	output logic                                            rd_fb
);
	import sdgc_pkg::*;

	localparam int SW  = $clog2(MAX_COLORS + 1);
	localparam int CLW = (MAX_COLORS > 1) ? $clog2(MAX_COLORS) : 1;
	localparam int EW  = SW + MAX_COLORS + CLW + 2;

	logic [EW-1:0]        ent_mem [MAX_NODES];
	logic [MAX_NODES-1:0] vld_q;
	logic [EW-1:0]        ent_s1;
	logic                 rvld_s1;
	logic [EW-1:0]        ent_rd;

	// Storage array, one write and one registered read per cycle.
	always_ff @(posedge clk) begin
		if (ctl.wr) begin
			ent_mem[wr_addr] <= {wr_sat, wr_mask, wr_color, wr_colored, wr_fb};
		end
		if (ctl.rd) begin
			ent_s1 <= ent_mem[rd_addr];
		end
	end

	// Valid bits: entries not written in the current run read as all zero.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q   <= '0;
			rvld_s1 <= 1'b0;
		end else begin
			if (ctl.clr) begin
				vld_q <= '0;
			end else if (ctl.wr) begin
				vld_q[wr_addr] <= 1'b1;
			end
			if (ctl.rd) begin
				rvld_s1 <= vld_q[rd_addr];
			end
		end
	end

	assign ent_rd = rvld_s1 ? ent_s1 : '0;
	assign {rd_sat, rd_mask, rd_color, rd_colored, rd_fb} = ent_rd;

endmodule

// File: sv/sdgc_mod.sv
// Bit-serial remainder unit for the fallback colour, one dividend bit per cycle.
`timescale 1ns / 1ps
module sdgc_mod #(
	parameter int KW = 5
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic [sdgc_pkg::LFSR_W-1:0] value,
	input  logic [KW-1:0]               divisor,
	output logic                        done,
	output logic [KW-1:0]               rem
);
	import sdgc_pkg::*;

	localparam int CW = $clog2(LFSR_W + 1);

	logic              busy_q;
	logic              done_q;
	logic [CW-1:0]     cnt_q;
	logic [LFSR_W-1:0] val_q;
	logic [KW-1:0]     div_q;
	logic [KW-1:0]     rem_q;
	logic [KW:0]       trial;
	logic [KW-1:0]     rem_nxt;

	// Restoring step: shift in the next bit, subtract the divisor when it fits.
	always_comb begin
		trial = {rem_q, val_q[LFSR_W-1]};
		if (trial >= {1'b0, div_q}) begin
			rem_nxt = KW'(trial - {1'b0, div_q});
		end else begin
			rem_nxt = KW'(trial);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CW'(LFSR_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - CW'(1);
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Operand and partial remainder registers.
	always_ff @(posedge clk) begin
		if (start) begin
			val_q <= value;
			div_q <= divisor;
			rem_q <= '0;
		end else if (busy_q) begin
			val_q <= val_q << 1;
			rem_q <= rem_nxt;
		end
	end

	assign done = done_q;
	assign rem  = rem_q;

endmodule

// File: sv/saturation_degree_graph_coloring.sv
// Top level of the DSATUR graph colouring engine: control sequencer and result register.
// A run does one selection scan and one neighbour update sweep per coloured node over the
// active nodes through the node store's single read port, plus a serial remainder for
// each node given a fallback colour.
// One word is worked on at a time; the next is accepted as soon as the result register frees.
// Reset: registers take their defaults and both stores read as zero through valid bits.
`timescale 1ns / 1ps
`include "saturation_degree_graph_coloring_assert.svh"
module saturation_degree_graph_coloring #(
	parameter int MAX_NODES  = sdgc_pkg::DEF_MAX_NODES,
	parameter int MAX_COLORS = sdgc_pkg::DEF_MAX_COLORS
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  op,
	input  logic [5:0]  node_a,
	input  logic [5:0]  node_b,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [3:0]  node_color,
	output logic        was_fallback,
	output logic [6:0]  fallback_total,
	output logic        status,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [15:0] cfg_data
);
	import sdgc_pkg::*;

	localparam int NW  = $clog2(MAX_NODES);
	localparam int DW  = $clog2(MAX_NODES + 1);
	localparam int NCW = (DW > 7) ? DW : 7;
	localparam int SW  = $clog2(MAX_COLORS + 1);
	localparam int CLW = (MAX_COLORS > 1) ? $clog2(MAX_COLORS) : 1;
	localparam int KW  = (SW > 5) ? SW : 5;

	state_t st_q, st_nxt;

	logic [6:0]  node_cnt_q;
	logic [4:0]  color_cnt_q;
	logic [15:0] seed_q;

	logic [1:0]  op_q;
	logic [5:0]  a_q;
	logic [5:0]  b_q;
	logic        out_valid_q;
	logic [CLW-1:0] color_q;
	logic        fb_q;
	logic        status_q;
	logic [DW-1:0] fcount_q;
	logic [LFSR_W-1:0] lfsr_q;

	logic [NCW-1:0] idx_q;
	logic [NW-1:0]  idx_s1;
	logic           rd_vld_s1;
	logic           best_vld_q;
	logic [NW-1:0]  best_q;
	logic [SW-1:0]  best_sat_q;
	logic [DW-1:0]  best_deg_q;
	logic [MAX_NODES-1:0]  row_q;
	logic [MAX_COLORS-1:0] mask_q;
	logic [SW-1:0]  sat_q;
	logic [CLW-1:0] chosen_q;
	logic           fb_pick_q;

	logic [NCW-1:0] act_n;
	logic [KW-1:0]  act_k;
	logic           in_fire;
	logic           a_ok, b_ok;
	logic           issue;
	logic           better;
	logic           add_new;
	logic           free_found;
	logic [CLW-1:0] free_color;
	logic           upd_hit;

	mem_ctl_t             g_ctl;
	logic [NW-1:0]        g_rd_addr, g_wr_addr;
	logic [MAX_NODES-1:0] g_wr_row, g_rd_row;
	logic [DW-1:0]        g_wr_deg, g_rd_deg;

	mem_ctl_t              n_ctl;
	logic [NW-1:0]         n_rd_addr, n_wr_addr;
	logic [SW-1:0]         n_wr_sat, n_rd_sat;
	logic [MAX_COLORS-1:0] n_wr_mask, n_rd_mask;
	logic [CLW-1:0]        n_wr_color, n_rd_color;
	logic                  n_wr_colored, n_rd_colored;
	logic                  n_wr_fb, n_rd_fb;

	logic           mod_start;
	logic           mod_done;
	logic [KW-1:0]  mod_rem;

	// Active node and colour counts.
	always_comb begin
		act_n = (NCW'(node_cnt_q) < NCW'(MAX_NODES)) ? NCW'(node_cnt_q) : NCW'(MAX_NODES);
		act_k = (KW'(color_cnt_q) < KW'(MAX_COLORS)) ? KW'(color_cnt_q) : KW'(MAX_COLORS);
		if (act_k == '0) begin
			act_k = KW'(1);
		end
	end

	assign in_ready  = (st_q == ST_IDLE) && (!out_valid_q || out_ready);
	assign in_fire   = in_valid && in_ready;
	assign cfg_ready = 1'b1;
	assign a_ok      = NCW'(node_a) < act_n;
	assign b_ok      = NCW'(node_b) < act_n;
	assign issue     = idx_q < act_n;

	// Selection compare: saturation first, then degree; ties keep the lower index.
	assign better = !n_rd_colored && (!best_vld_q || (n_rd_sat > best_sat_q) ||
		((n_rd_sat == best_sat_q) && (g_rd_deg > best_deg_q)));

	assign add_new = !g_rd_row[NW'(b_q)];

	// Smallest colour not used by a coloured neighbour.
	always_comb begin
		free_found = 1'b0;
		free_color = '0;
		for (int c = MAX_COLORS - 1; c >= 0; c--) begin
			if ((KW'(c) < act_k) && !n_rd_mask[c]) begin
				free_found = 1'b1;
				free_color = CLW'(c);
			end
		end
	end

	assign upd_hit = rd_vld_s1 && row_q[idx_s1] && !n_rd_colored && !n_rd_mask[chosen_q];

	// Next state.
	always_comb begin
		st_nxt = st_q;
		unique case (st_q)
			ST_IDLE: begin
				if (in_fire) begin
					unique case (op_t'(op))
						OP_ADD:   st_nxt = (a_ok && b_ok) ? ST_ADD_A : ST_DONE;
						OP_CLEAR: st_nxt = ST_DONE;
						OP_RUN:   st_nxt = ST_SCAN;
						OP_READ:  st_nxt = a_ok ? ST_READ : ST_DONE;
						default:  st_nxt = ST_DONE;
					endcase
				end
			end
			ST_ADD_A:  st_nxt = (add_new && (a_q != b_q)) ? ST_ADD_B : ST_DONE;
			ST_ADD_B:  st_nxt = ST_DONE;
			ST_READ:   st_nxt = ST_DONE;
			ST_SCAN: begin
				if (!issue && !rd_vld_s1) begin
					st_nxt = best_vld_q ? ST_CHOOSE : ST_DONE;
				end
			end
			ST_CHOOSE: st_nxt = free_found ? ST_COMMIT : ST_MOD;
			ST_MOD:    st_nxt = mod_done ? ST_COMMIT : ST_MOD;
			ST_COMMIT: st_nxt = ST_UPD;
			ST_UPD:    st_nxt = (!issue && !rd_vld_s1) ? ST_SCAN : ST_UPD;
			ST_DONE:   st_nxt = ST_IDLE;
			default:   st_nxt = ST_IDLE;
		endcase
	end

	// Store and unit controls.
	always_comb begin
		g_ctl        = '0;
		g_rd_addr    = NW'(node_a);
		g_wr_addr    = NW'(a_q);
		g_wr_row     = g_rd_row;
		g_wr_deg     = g_rd_deg + DW'(1);
		n_ctl        = '0;
		n_rd_addr    = NW'(idx_q);
		n_wr_addr    = idx_s1;
		n_wr_sat     = n_rd_sat + SW'(1);
		n_wr_mask    = n_rd_mask;
		n_wr_color   = n_rd_color;
		n_wr_colored = n_rd_colored;
		n_wr_fb      = n_rd_fb;
		mod_start    = 1'b0;
		unique case (st_q)
			ST_IDLE: begin
				if (in_fire) begin
					n_rd_addr = NW'(node_a);
					unique case (op_t'(op))
						OP_ADD:   g_ctl.rd  = a_ok && b_ok;
						OP_CLEAR: g_ctl.clr = 1'b1;
						OP_RUN:   n_ctl.clr = 1'b1;
						OP_READ:  n_ctl.rd  = a_ok;
						default:  g_ctl     = '0;
					endcase
				end
			end
			ST_ADD_A: begin
				g_wr_row[NW'(b_q)] = 1'b1;
				g_ctl.wr  = add_new;
				g_ctl.rd  = add_new && (a_q != b_q);
				g_rd_addr = NW'(b_q);
			end
			ST_ADD_B: begin
				g_wr_addr          = NW'(b_q);
				g_wr_row[NW'(a_q)] = 1'b1;
				g_ctl.wr           = 1'b1;
			end
			ST_SCAN: begin
				if (issue) begin
					g_ctl.rd  = 1'b1;
					n_ctl.rd  = 1'b1;
					g_rd_addr = NW'(idx_q);
				end else if (!rd_vld_s1 && best_vld_q) begin
					g_ctl.rd  = 1'b1;
					n_ctl.rd  = 1'b1;
					g_rd_addr = best_q;
					n_rd_addr = best_q;
				end
			end
			ST_CHOOSE: mod_start = !free_found;
			ST_COMMIT: begin
				n_ctl.wr     = 1'b1;
				n_wr_addr    = best_q;
				n_wr_sat     = sat_q;
				n_wr_mask    = mask_q;
				n_wr_color   = chosen_q;
				n_wr_colored = 1'b1;
				n_wr_fb      = fb_pick_q;
			end
			ST_UPD: begin
				n_ctl.rd = issue;
				n_ctl.wr = upd_hit;
				n_wr_mask[chosen_q] = 1'b1;
			end
			ST_READ, ST_MOD, ST_DONE: n_ctl = '0;
			default: n_ctl = '0;
		endcase
	end

	// Control registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q        <= ST_IDLE;
			out_valid_q <= 1'b0;
			node_cnt_q  <= RST_NODE_COUNT;
			color_cnt_q <= RST_COLOR_COUNT;
			seed_q      <= RST_SEED;
			fcount_q    <= '0;
			lfsr_q      <= LFSR_W'(1);
			rd_vld_s1   <= 1'b0;
			best_vld_q  <= 1'b0;
			idx_q       <= '0;
		end else begin
			st_q <= st_nxt;
			if (st_q == ST_DONE) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_NODE_COUNT:  node_cnt_q  <= cfg_data[6:0];
					REG_COLOR_COUNT: color_cnt_q <= cfg_data[4:0];
					REG_SEED:        seed_q      <= cfg_data;
					default:         seed_q      <= seed_q;
				endcase
			end
			case (st_q)
				ST_IDLE: begin
					if (in_fire && (op_t'(op) == OP_RUN)) begin
						fcount_q   <= '0;
						lfsr_q     <= (seed_q == '0) ? LFSR_W'(1) : seed_q;
						idx_q      <= '0;
						rd_vld_s1  <= 1'b0;
						best_vld_q <= 1'b0;
					end
				end
				ST_SCAN: begin
					rd_vld_s1 <= issue;
					if (issue) begin
						idx_q <= idx_q + NCW'(1);
					end
					if (rd_vld_s1 && better) begin
						best_vld_q <= 1'b1;
					end
				end
				ST_CHOOSE: begin
					if (!free_found) begin
						lfsr_q <= lfsr_step(lfsr_q);
					end
				end
				ST_MOD: begin
					if (mod_done) begin
						fcount_q <= fcount_q + DW'(1);
					end
				end
				ST_COMMIT: begin
					idx_q     <= '0;
					rd_vld_s1 <= 1'b0;
				end
				ST_UPD: begin
					rd_vld_s1 <= issue;
					if (issue) begin
						idx_q <= idx_q + NCW'(1);
					end else if (!rd_vld_s1) begin
						idx_q      <= '0;
						best_vld_q <= 1'b0;
					end
				end
				default: begin
					rd_vld_s1 <= rd_vld_s1;
				end
			endcase
		end
	end

	// Payload registers.
	always_ff @(posedge clk) begin
		if (in_fire) begin
			op_q     <= op;
			a_q      <= node_a;
			b_q      <= node_b;
			color_q  <= '0;
			fb_q     <= 1'b0;
			status_q <= ((op_t'(op) == OP_ADD) && !(a_ok && b_ok)) ||
				((op_t'(op) == OP_READ) && !a_ok);
		end
		if ((st_q == ST_READ) && (op_t'(op_q) == OP_READ)) begin
			color_q <= n_rd_color;
			fb_q    <= n_rd_fb;
		end
		if ((st_q == ST_SCAN) || (st_q == ST_UPD)) begin
			idx_s1 <= NW'(idx_q);
		end
		if ((st_q == ST_SCAN) && rd_vld_s1 && better) begin
			best_q     <= idx_s1;
			best_sat_q <= n_rd_sat;
			best_deg_q <= g_rd_deg;
		end
		if (st_q == ST_CHOOSE) begin
			row_q     <= g_rd_row;
			mask_q    <= n_rd_mask;
			sat_q     <= n_rd_sat;
			chosen_q  <= free_color;
			fb_pick_q <= 1'b0;
		end
		if ((st_q == ST_MOD) && mod_done) begin
			chosen_q  <= CLW'(mod_rem);
			fb_pick_q <= 1'b1;
		end
	end

	sdgc_graph_mem #(
		.MAX_NODES (MAX_NODES)
	) u_graph (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctl     (g_ctl),
		.rd_addr (g_rd_addr),
		.wr_addr (g_wr_addr),
		.wr_row  (g_wr_row),
		.wr_deg  (g_wr_deg),
		.rd_row  (g_rd_row),
		.rd_deg  (g_rd_deg)
	);

	sdgc_node_mem #(
		.MAX_NODES  (MAX_NODES),
		.MAX_COLORS (MAX_COLORS)
	) u_node (
		.clk        (clk),
		.arst_n     (arst_n),
		.ctl        (n_ctl),
		.rd_addr    (n_rd_addr),
		.wr_addr    (n_wr_addr),
		.wr_sat     (n_wr_sat),
		.wr_mask    (n_wr_mask),
		.wr_color   (n_wr_color),
		.wr_colored (n_wr_colored),
		.wr_fb      (n_wr_fb),
		.rd_sat     (n_rd_sat),
		.rd_mask    (n_rd_mask),
		.rd_color   (n_rd_color),
		.rd_colored (n_rd_colored),
		.rd_fb      (n_rd_fb)
	);

	sdgc_mod #(
		.KW (KW)
	) u_mod (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (mod_start),
		.value   (lfsr_step(lfsr_q)),
		.divisor (act_k),
		.done    (mod_done),
		.rem     (mod_rem)
	);

	assign out_valid      = out_valid_q;
	assign node_color     = 4'(color_q);
	assign was_fallback   = fb_q;
	assign fallback_total = 7'(fcount_q);
	assign status         = status_q;

	// Checks on the sequencer and store access ordering.
	`SDGC_ASSERT_NEXT(a_accept_moves, in_valid && in_ready, st_q != ST_IDLE, "accepted word left idle")
	`SDGC_ASSERT(a_done_slot_free, (st_q != ST_DONE) || !out_valid_q, "result register busy at finish")
	`SDGC_ASSERT(a_graph_no_clash, !(g_ctl.wr && g_ctl.rd) || (g_wr_addr != g_rd_addr), "graph store clash")
	`SDGC_ASSERT(a_node_no_clash, !(n_ctl.wr && n_ctl.rd) || (n_wr_addr != n_rd_addr), "node store clash")
	`SDGC_ASSERT(a_mod_done_state, !mod_done || (st_q == ST_MOD), "remainder ready outside wait state")

endmodule
